// File: src/char_lcd_4bit_message_writer_macros.svh
// Assertion macros used by the character display writer back end.
`ifndef CHAR_LCD_4BIT_MESSAGE_WRITER_MACROS_SVH
`define CHAR_LCD_4BIT_MESSAGE_WRITER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CLW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("char display writer assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CLW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("char display writer assertion failed");

`endif

// File: src/clw_pkg.sv
// Shared types and constants for the character display message writer.
package clw_pkg;

	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_CHAR  = 2'd2;

	localparam logic [1:0] REG_SETTLE = 2'd0;
	localparam logic [1:0] REG_BYTE   = 2'd1;
	localparam logic [1:0] REG_CLEAR  = 2'd2;

	localparam logic [7:0] CMD_FUNCSET = 8'h28;
	localparam logic [7:0] CMD_DISPON  = 8'h0C;
	localparam logic [7:0] CMD_ENTRY   = 8'h06;
	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [7:0] CMD_DDRAM   = 8'h80;
	localparam logic [7:0] ROW2_ADDR   = 8'h40;
	localparam logic [3:0] WAKE_NIB    = 4'h3;
	localparam logic [3:0] FOURBIT_NIB = 4'h2;
	localparam logic [7:0] NIB_MASK    = 8'h0F;

	localparam logic [15:0] WAKE_FIRST_US  = 16'd5000;
	localparam logic [15:0] WAKE_SECOND_US = 16'd1000;

	localparam logic [9:0]  SETTLE_RST = 10'd100;
	localparam logic [13:0] BYTE_RST   = 14'd2000;
	localparam logic [13:0] CLEAR_RST  = 14'd5000;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [3:0] INIT_STEPS  = 4'd12;
	localparam logic [3:0] START_STEPS = 4'd4;
	localparam logic [3:0] CHAR_STEPS  = 4'd2;
	localparam logic [3:0] ROW2_STEPS  = 4'd4;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] char_code;
	} in_item_t;

	typedef struct packed {
		logic        rs;
		logic [3:0]  nibble;
		logic [15:0] wait_us;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [9:0]  settle_us;
		logic [13:0] byte_us;
		logic [13:0] clear_us;
	} cfg_t;

	typedef enum logic [1:0] {
		JOB_INIT,
		JOB_START,
		JOB_CHAR,
		JOB_ROW2
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] code;
	} job_t;

endpackage

// File: src/clw_front.sv
// Front end: accepts items, tracks the cursor position and queues strobe jobs.
module clw_front #(
	parameter int COLUMNS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            full,
	input  clw_pkg::in_item_t item,
	output logic            job_push,
	output clw_pkg::job_t   job
);

	localparam int POS_W = $clog2(2 * COLUMNS + 1);
	localparam logic [POS_W-1:0] POS_CLOSED = POS_W'(2 * COLUMNS);
	localparam logic [POS_W-1:0] POS_ROW2   = POS_W'(COLUMNS);

	logic             accept;
	logic [POS_W-1:0] position_q;
	logic [POS_W-1:0] position_d;

	assign accept = push && !full;

	always_comb begin
		position_d = position_q;
		job_push   = 1'b0;
		job.kind   = clw_pkg::JOB_CHAR;
		job.code   = item.char_code;
		unique case (item.op)
			clw_pkg::OP_INIT: begin
				job_push   = accept;
				job.kind   = clw_pkg::JOB_INIT;
				position_d = POS_CLOSED;
			end
			clw_pkg::OP_START: begin
				job_push   = accept;
				job.kind   = clw_pkg::JOB_START;
				position_d = '0;
			end
			clw_pkg::OP_CHAR: begin
				if (item.char_code == 8'h00) begin
					position_d = POS_CLOSED;
				end else if (position_q < POS_CLOSED) begin
					job_push   = accept;
					job.kind   = (position_q == POS_ROW2) ? clw_pkg::JOB_ROW2 : clw_pkg::JOB_CHAR;
					position_d = position_q + POS_W'(1);
				end
			end
			default: begin
				position_d = position_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= POS_CLOSED;
		end else if (accept) begin
			position_q <= position_d;
		end
	end

endmodule

// File: src/clw_queue.sv
// Short job queue between the front end and the strobe sequencer.
module clw_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  clw_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output logic          rd_valid,
	output clw_pkg::job_t rd_data
);

	clw_pkg::job_t                   mem_q [clw_pkg::QUEUE_DEPTH];
	logic [clw_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [clw_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [clw_pkg::QCNT_W-1:0]      count_q;
	logic                            do_wr;
	logic                            do_rd;

	assign full     = (count_q == clw_pkg::QCNT_W'(clw_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + clw_pkg::QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + clw_pkg::QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + clw_pkg::QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - clw_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// File: src/clw_back.sv
// Back end: steps through the strobes of each job and holds the result register.
`include "char_lcd_4bit_message_writer_macros.svh"

module clw_back (
	input  logic               clk,
	input  logic               arst_n,
	input  clw_pkg::cfg_t      cfg,
	input  logic               job_valid,
	input  clw_pkg::job_t      job,
	output logic               job_pop,
	input  logic               pop,
	output logic               empty,
	output clw_pkg::out_item_t result
);

	logic [3:0]         step_q;
	logic [3:0]         n_steps;
	logic [3:0]         init_off;
	logic               rs_c;
	logic [7:0]         byte_c;
	logic               wake_c;
	logic               half_c;
	logic               last_c;
	logic [15:0]        extra_c;
	logic               advance;
	logic               out_valid_q;
	clw_pkg::out_item_t out_q;
	clw_pkg::out_item_t strobe_c;

	assign init_off = step_q - 4'd4;
	assign half_c   = step_q[0];

	always_comb begin
		rs_c    = 1'b0;
		byte_c  = clw_pkg::CMD_CLEAR;
		wake_c  = 1'b0;
		n_steps = clw_pkg::CHAR_STEPS;
		unique case (job.kind)
			clw_pkg::JOB_INIT: begin
				n_steps = clw_pkg::INIT_STEPS;
				wake_c  = (step_q < 4'd4);
				case (init_off[2:1])
					2'd0:    byte_c = clw_pkg::CMD_FUNCSET;
					2'd1:    byte_c = clw_pkg::CMD_DISPON;
					2'd2:    byte_c = clw_pkg::CMD_ENTRY;
					default: byte_c = clw_pkg::CMD_CLEAR;
				endcase
			end
			clw_pkg::JOB_START: begin
				n_steps = clw_pkg::START_STEPS;
				byte_c  = step_q[1] ? clw_pkg::CMD_DDRAM : clw_pkg::CMD_CLEAR;
			end
			clw_pkg::JOB_CHAR: begin
				n_steps = clw_pkg::CHAR_STEPS;
				rs_c    = 1'b1;
				byte_c  = job.code;
			end
			clw_pkg::JOB_ROW2: begin
				n_steps = clw_pkg::ROW2_STEPS;
				rs_c    = step_q[1];
				byte_c  = step_q[1] ? job.code : (clw_pkg::CMD_DDRAM | clw_pkg::ROW2_ADDR);
			end
			default: begin
				n_steps = clw_pkg::CHAR_STEPS;
			end
		endcase
	end

	always_comb begin
		extra_c = '0;
		if (wake_c) begin
			if (step_q == 4'd0) begin
				extra_c = clw_pkg::WAKE_FIRST_US;
			end else if (step_q == 4'd1) begin
				extra_c = clw_pkg::WAKE_SECOND_US;
			end
		end else if (half_c) begin
			extra_c = {2'b00, cfg.byte_us};
			if (!rs_c && byte_c == clw_pkg::CMD_CLEAR) begin
				extra_c = {2'b00, cfg.byte_us} + {2'b00, cfg.clear_us};
			end
		end
	end

	assign last_c = (step_q == n_steps - 4'd1);

	always_comb begin
		strobe_c.rs      = rs_c;
		strobe_c.wait_us = {6'b000000, cfg.settle_us} + extra_c;
		strobe_c.last    = last_c;
		if (wake_c) begin
			strobe_c.nibble = (step_q == 4'd3) ? clw_pkg::FOURBIT_NIB : clw_pkg::WAKE_NIB;
		end else if (half_c) begin
			strobe_c.nibble = 4'(byte_c & clw_pkg::NIB_MASK);
		end else begin
			strobe_c.nibble = byte_c[7:4];
		end
	end

	assign advance = job_valid && (!out_valid_q || pop);
	assign job_pop = advance && last_c;
	assign empty   = !out_valid_q;
	assign result  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q      <= last_c ? 4'd0 : step_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= strobe_c;
		end
	end

	`CLW_ASSERT_NOW(a_step_in_range, job_valid, step_q < n_steps)
	`CLW_ASSERT_NOW(a_step_needs_job, step_q != 4'd0, job_valid)
	`CLW_ASSERT_NEXT(a_step_wraps, advance && last_c, step_q == 4'd0)
	`CLW_ASSERT_NEXT(a_strobe_loaded, advance, !empty)

endmodule

// File: src/char_lcd_4bit_message_writer.sv
// Top level of the 4-bit character display message writer.
// Turns init, start and character items into display enable strobes, each with its
// register-select bit, nibble and hold-off time. An item is taken in the cycle it is
// offered whenever the four-entry job queue has room; items that cause no strobe
// still pass through the front end. The strobe sequencer issues one strobe per cycle
// into the result register while it is empty or being popped, and an item yields 2,
// 4 or 12 strobes; the first strobe of an item passes through the job queue into the
// result register behind any earlier job still in the queue or the result register.
module char_lcd_4bit_message_writer #(
	parameter int COLUMNS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  clw_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output clw_pkg::out_item_t result,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [13:0]        cfg_wdata
);

	clw_pkg::cfg_t cfg_q;
	clw_pkg::job_t front_job;
	clw_pkg::job_t queue_job;
	logic          front_push;
	logic          queue_valid;
	logic          queue_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_us <= clw_pkg::SETTLE_RST;
			cfg_q.byte_us   <= clw_pkg::BYTE_RST;
			cfg_q.clear_us  <= clw_pkg::CLEAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				clw_pkg::REG_SETTLE: cfg_q.settle_us <= cfg_wdata[9:0];
				clw_pkg::REG_BYTE:   cfg_q.byte_us   <= cfg_wdata;
				clw_pkg::REG_CLEAR:  cfg_q.clear_us  <= cfg_wdata;
				default:             cfg_q           <= cfg_q;
			endcase
		end
	end

	clw_front #(
		.COLUMNS(COLUMNS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.job_push(front_push),
		.job     (front_job)
	);

	clw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_push),
		.wr_data (front_job),
		.full    (full),
		.rd_en   (queue_pop),
		.rd_valid(queue_valid),
		.rd_data (queue_job)
	);

	clw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job_valid(queue_valid),
		.job      (queue_job),
		.job_pop  (queue_pop),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

// File: test/tb.sv
// Self-checking testbench for the 4-bit character display message writer.
`timescale 1ns / 100ps

module tb;

	localparam int COLUMNS = 16;
	localparam int MSG_CLOSED = 2 * COLUMNS;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		clw_pkg::in_item_t  item;
		int                 reps;
		bit                 typed;
		clw_pkg::out_item_t first;
	} script_row_t;

	localparam int SCRIPT_LEN = 22;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               push;
	logic               full;
	clw_pkg::in_item_t  item;
	logic               empty;
	logic               pop;
	clw_pkg::out_item_t result;
	logic               cfg_we;
	logic [1:0]         cfg_idx;
	logic [13:0]        cfg_wdata;

	clw_pkg::out_item_t strobes_due[$];
	clw_pkg::out_item_t strobe_want;
	bit          any_mismatch = 1'b0;
	bit          steady_flow = 1'b0;
	int unsigned pop_hold = 0;

	int unsigned line_pos;
	int unsigned settle_time;
	int unsigned byte_time;
	int unsigned clear_time;

	script_row_t script [SCRIPT_LEN] = '{
		'{'{clw_pkg::OP_CHAR, 8'h41}, 1, 1'b0, '0},
		'{'{OP_UNUSED, 8'hFF}, 1, 1'b0, '0},
		'{'{clw_pkg::OP_INIT, 8'h00}, 1, 1'b1,
			'{1'b0, clw_pkg::WAKE_NIB, 16'd5100, 1'b0}},
		'{'{clw_pkg::OP_CHAR, 8'h42}, 1, 1'b0, '0},
		'{'{clw_pkg::OP_START, 8'hFF}, 1, 1'b1, '{1'b0, 4'h0, 16'd100, 1'b0}},
		'{'{clw_pkg::OP_CHAR, 8'hFF}, 1, 1'b1, '{1'b1, 4'hF, 16'd100, 1'b0}},
		'{'{clw_pkg::OP_CHAR, 8'h01}, 1, 1'b1, '{1'b1, 4'h0, 16'd100, 1'b0}},
		'{'{clw_pkg::OP_CHAR, 8'h20}, 13, 1'b0, '0},
		'{'{clw_pkg::OP_CHAR, 8'h80}, 1, 1'b1, '{1'b1, 4'h8, 16'd100, 1'b0}},
		'{'{clw_pkg::OP_CHAR, 8'h7E}, 1, 1'b1, '{1'b0, 4'hC, 16'd100, 1'b0}},
		'{'{clw_pkg::OP_CHAR, 8'h30}, 15, 1'b0, '0},
		'{'{clw_pkg::OP_CHAR, 8'h55}, 1, 1'b0, '0},
		'{'{clw_pkg::OP_CHAR, 8'h00}, 1, 1'b0, '0},
		'{'{clw_pkg::OP_CHAR, 8'h61}, 1, 1'b0, '0},
		'{'{clw_pkg::OP_START, 8'h00}, 1, 1'b0, '0},
		'{'{clw_pkg::OP_CHAR, 8'hAA}, 1, 1'b0, '0},
		'{'{OP_UNUSED, 8'h00}, 1, 1'b0, '0},
		'{'{clw_pkg::OP_CHAR, 8'h5A}, 1, 1'b0, '0},
		'{'{clw_pkg::OP_INIT, 8'hFF}, 1, 1'b0, '0},
		'{'{clw_pkg::OP_CHAR, 8'h42}, 1, 1'b0, '0},
		'{'{clw_pkg::OP_START, 8'h00}, 1, 1'b0, '0},
		'{'{clw_pkg::OP_CHAR, 8'h00}, 1, 1'b0, '0}
	};

	char_lcd_4bit_message_writer #(
		.COLUMNS(COLUMNS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady_flow || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void put_nibble(bit rs, logic [3:0] nib, int unsigned us);
		clw_pkg::out_item_t s;
		s.rs = rs;
		s.nibble = nib;
		s.wait_us = 16'(us);
		s.last = 1'b0;
		strobes_due.push_back(s);
	endfunction

	function automatic void put_byte(bit rs, logic [7:0] b);
		int unsigned tail;
		tail = settle_time + byte_time;
		if (!rs && b == clw_pkg::CMD_CLEAR)
			tail += clear_time;
		put_nibble(rs, b[7:4], settle_time);
		put_nibble(rs, b[3:0], tail);
	endfunction

	function automatic int predict_strobes(clw_pkg::in_item_t it);
		int before_n;
		before_n = strobes_due.size();
		case (it.op)
			clw_pkg::OP_INIT: begin
				put_nibble(1'b0, clw_pkg::WAKE_NIB, settle_time + clw_pkg::WAKE_FIRST_US);
				put_nibble(1'b0, clw_pkg::WAKE_NIB, settle_time + clw_pkg::WAKE_SECOND_US);
				put_nibble(1'b0, clw_pkg::WAKE_NIB, settle_time);
				put_nibble(1'b0, clw_pkg::FOURBIT_NIB, settle_time);
				put_byte(1'b0, clw_pkg::CMD_FUNCSET);
				put_byte(1'b0, clw_pkg::CMD_DISPON);
				put_byte(1'b0, clw_pkg::CMD_ENTRY);
				put_byte(1'b0, clw_pkg::CMD_CLEAR);
				line_pos = MSG_CLOSED;
			end
			clw_pkg::OP_START: begin
				put_byte(1'b0, clw_pkg::CMD_CLEAR);
				put_byte(1'b0, clw_pkg::CMD_DDRAM);
				line_pos = 0;
			end
			clw_pkg::OP_CHAR: begin
				if (it.char_code == 8'h00) begin
					line_pos = MSG_CLOSED;
				end else if (line_pos < MSG_CLOSED) begin
					if (line_pos == COLUMNS)
						put_byte(1'b0, clw_pkg::CMD_DDRAM | clw_pkg::ROW2_ADDR);
					put_byte(1'b1, it.char_code);
					line_pos++;
				end
			end
			default: begin
			end
		endcase
		if (strobes_due.size() > before_n)
			strobes_due[strobes_due.size() - 1].last = 1'b1;
		return strobes_due.size() - before_n;
	endfunction

	task automatic drive_item(clw_pkg::in_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk) push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
	endtask

	task automatic send(clw_pkg::in_item_t it);
		drive_item(it);
		void'(predict_strobes(it));
	endtask

	task automatic drain();
		@(negedge clk) push <= 1'b0;
		while (strobes_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_timing(logic [13:0] s, logic [13:0] b, logic [13:0] c, bit poke_unused);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= clw_pkg::REG_SETTLE;
		cfg_wdata <= s;
		@(negedge clk);
		cfg_idx <= clw_pkg::REG_BYTE;
		cfg_wdata <= b;
		@(negedge clk);
		cfg_idx <= clw_pkg::REG_CLEAR;
		cfg_wdata <= c;
		if (poke_unused) begin
			@(negedge clk);
			cfg_idx <= REG_UNUSED;
			cfg_wdata <= ~s;
		end
		@(negedge clk) cfg_we <= 1'b0;
		settle_time = s[9:0];
		byte_time = b;
		clear_time = c;
	endtask

	task automatic random_traffic(int target);
		int sent;
		int len;
		clw_pkg::in_item_t it;
		sent = 0;
		while (sent < target) begin
			case ($urandom_range(0, 99)) inside
				[0:74]: begin
					it.op = clw_pkg::OP_START;
					it.char_code = 8'($urandom_range(0, 255));
					send(it);
					if ($urandom_range(0, 99) < 70)
						len = $urandom_range(0, 20);
					else
						len = $urandom_range(14, 36);
					for (int k = 0; k < len; k++) begin
						it.op = clw_pkg::OP_CHAR;
						it.char_code = 8'($urandom_range(1, 255));
						send(it);
					end
					if ($urandom_range(0, 3) != 0) begin
						it.op = clw_pkg::OP_CHAR;
						it.char_code = 8'h00;
						send(it);
					end
					sent += len + 2;
				end
				[75:81]: begin
					it.op = clw_pkg::OP_INIT;
					it.char_code = 8'($urandom_range(0, 255));
					send(it);
					sent++;
				end
				default: begin
					it.op = 2'($urandom_range(0, 3));
					it.char_code = 8'($urandom_range(0, 255));
					send(it);
					if (it.op != OP_UNUSED)
						sent++;
				end
			endcase
		end
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold != 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else begin
			pop <= 1'b1;
			if (!steady_flow && $urandom_range(0, 99) < 20)
				pop_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (strobes_due.size() == 0) begin
				$error("unexpected strobe: rs %0b nibble %h wait_us %0d last %0b",
					result.rs, result.nibble, result.wait_us, result.last);
				any_mismatch = 1'b1;
			end else begin
				strobe_want = strobes_due.pop_front();
				if (result.rs !== strobe_want.rs) begin
					$error("rs: expected %0b, got %0b", strobe_want.rs, result.rs);
					any_mismatch = 1'b1;
				end
				if (result.nibble !== strobe_want.nibble) begin
					$error("nibble: expected %h, got %h", strobe_want.nibble, result.nibble);
					any_mismatch = 1'b1;
				end
				if (result.wait_us !== strobe_want.wait_us) begin
					$error("wait_us: expected %0d, got %0d", strobe_want.wait_us,
						result.wait_us);
					any_mismatch = 1'b1;
				end
				if (result.last !== strobe_want.last) begin
					$error("last: expected %0b, got %0b", strobe_want.last, result.last);
					any_mismatch = 1'b1;
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("char_lcd_4bit_message_writer verification failed");
		$finish;
	end

	initial begin
		clw_pkg::in_item_t it;
		int n;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		pop = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = clw_pkg::REG_SETTLE;
		cfg_wdata = '0;
		settle_time = clw_pkg::SETTLE_RST;
		byte_time = clw_pkg::BYTE_RST;
		clear_time = clw_pkg::CLEAR_RST;
		line_pos = MSG_CLOSED;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			for (int k = 0; k < script[i].reps; k++) begin
				it = script[i].item;
				it.char_code = script[i].item.char_code + 8'(k);
				drive_item(it);
				n = predict_strobes(it);
				if (script[i].typed && n > 0)
					strobes_due[strobes_due.size() - n] = script[i].first;
			end
		end

		drain();
		steady_flow = 1'b1;
		load_timing(14'h0000, 14'h0000, 14'h0000, 1'b1);
		random_traffic(50);

		drain();
		steady_flow = 1'b0;
		load_timing(14'h3FFF, 14'h3FFF, 14'h3FFF, 1'b0);
		random_traffic(50);

		drain();
		load_timing(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)),
			14'($urandom_range(0, 16383)), 1'b1);
		random_traffic(50);

		drain();
		load_timing({4'hA, clw_pkg::SETTLE_RST}, clw_pkg::BYTE_RST, clw_pkg::CLEAR_RST, 1'b0);
		random_traffic(45);

		@(negedge clk) push <= 1'b0;
		while (strobes_due.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (!any_mismatch && strobes_due.size() == 0)
			$display("char_lcd_4bit_message_writer verification clean");
		else
			$display("char_lcd_4bit_message_writer verification failed");
		$finish;
	end

endmodule

// File: char_lcd_4bit_message_writer.f
+incdir+src
src/clw_pkg.sv
src/clw_front.sv
src/clw_queue.sv
src/clw_back.sv
src/char_lcd_4bit_message_writer.sv
test/tb.sv
